// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file of the design, aip_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property on the rising clock edge, switched off while reset is asserted.
`define AIP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same-cycle implication on the rising clock edge, switched off in reset.
`define AIP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- design/aip_pkg.sv -----
// Types, codes and constants of the ASCII integer parser.
// Used by the parser core, its step logic and its checker.
package aip_pkg;

    localparam int COUNT_BITS = 16;
    localparam int USED_W     = 16;
    localparam int CONS_W     = 16;
    localparam int DIFF_W     = (COUNT_BITS > CONS_W) ? COUNT_BITS : CONS_W;
    localparam int ACC_W      = 64;
    localparam int BASE_W     = 5;

    typedef logic [ACC_W-1:0]      t_acc;
    typedef logic [USED_W-1:0]     t_used;
    typedef logic [COUNT_BITS-1:0] t_total;
    typedef logic [DIFF_W-1:0]     t_diff;
    typedef logic [BASE_W-1:0]     t_base;

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_PREFIX,
        PH_HOLD,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_EMPTY,
        OP_SPACE,
        OP_SIGN,
        OP_HOLD,
        OP_XPFX,
        OP_DIGIT
    } t_op;

    localparam logic [2:0] CFG_BASE_MODE     = 3'd0;
    localparam logic [2:0] CFG_IS_SIGNED     = 3'd1;
    localparam logic [2:0] CFG_STORE_SIZE    = 3'd2;
    localparam logic [2:0] CFG_WIDTH_LIMITED = 3'd3;
    localparam logic [2:0] CFG_FIELD_WIDTH   = 3'd4;

    localparam logic [2:0] BM_DEC  = 3'd0;
    localparam logic [2:0] BM_AUTO = 3'd1;
    localparam logic [2:0] BM_OCT  = 3'd2;
    localparam logic [2:0] BM_HEX  = 3'd3;
    localparam logic [2:0] BM_BIN  = 3'd4;

    localparam t_base BASE_AUTO = 5'd0;
    localparam t_base BASE_2    = 5'd2;
    localparam t_base BASE_8    = 5'd8;
    localparam t_base BASE_10   = 5'd10;
    localparam t_base BASE_16   = 5'd16;

    localparam logic [1:0] SZ_8  = 2'd0;
    localparam logic [1:0] SZ_16 = 2'd1;
    localparam logic [1:0] SZ_32 = 2'd2;
    localparam logic [1:0] SZ_64 = 2'd3;

    localparam logic [1:0] ST_MATCH     = 2'd0;
    localparam logic [1:0] ST_NO_DIGITS = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    typedef struct packed {
        logic [2:0]  base_mode;
        logic        is_signed;
        logic [1:0]  store_size;
        logic        width_limited;
        logic [15:0] field_width;
    } t_cfg;

    typedef struct packed {
        t_phase phase;
        t_acc   acc;
        t_acc   nacc;
        t_used  used;
        t_total total;
        t_base  base;
        logic   minus;
        logic   dseen;
    } t_state;

    typedef struct packed {
        t_acc        value;
        logic        negative;
        logic [1:0]  status;
        logic [15:0] consumed;
    } t_result;

    localparam t_cfg CFG_RESET = '{
        base_mode:     BM_DEC,
        is_signed:     1'b1,
        store_size:    SZ_32,
        width_limited: 1'b0,
        field_width:   16'd0
    };

    localparam t_state STATE_CLEAR = '{
        phase: PH_SKIP,
        acc:   '0,
        nacc:  '0,
        used:  '0,
        total: '0,
        base:  BASE_10,
        minus: 1'b0,
        dseen: 1'b0
    };

endpackage

// ----- design/aip_step.sv -----
// Combinational step logic of the parser: decodes one character against the
// parse state and gives the next state and the result, if any. Uses aip_pkg.
module aip_step (
    input  aip_pkg::t_state  i_state,
    input  aip_pkg::t_cfg    i_cfg,
    input  logic [7:0]       i_ch,
    input  logic             i_last,
    output aip_pkg::t_state  o_state,
    output logic             o_emit,
    output aip_pkg::t_result o_result
);

    logic is_nul, is_ws, is_minus, is_sign, is_x, is_zero;
    logic dig_valid, dig_ok;
    logic [5:0] dig;
    aip_pkg::t_base base_sel, start_b, b_d;
    logic sign_ok, hold_ok, room2, pre_inc;
    aip_pkg::t_op op;
    aip_pkg::t_used used1, used2, used_in, used_out;
    aip_pkg::t_total total1, total2, total_in, total_out;
    logic wh_r, wh_1, wh_2, wh_in, wh_out;
    logic dseen_in, stop, ds_emit;
    aip_pkg::t_acc mul_p, mul_n, acc_new, nacc_new;
    logic fdseen, fempty;
    aip_pkg::t_acc facc, fnacc, sel;
    aip_pkg::t_used fused;
    aip_pkg::t_total ftotal;
    aip_pkg::t_diff tot_x, use_x, diff;

    assign is_nul   = (i_ch == aip_pkg::CH_NUL);
    assign is_ws    = (i_ch == aip_pkg::CH_SPACE) ||
                      (i_ch >= aip_pkg::CH_TAB && i_ch <= aip_pkg::CH_CR);
    assign is_minus = (i_ch == aip_pkg::CH_MINUS);
    assign is_sign  = is_minus || (i_ch == aip_pkg::CH_PLUS);
    assign is_x     = (i_ch == aip_pkg::CH_LX) || (i_ch == aip_pkg::CH_UX);
    assign is_zero  = (i_ch == aip_pkg::CH_ZERO);

    always_comb begin
        dig       = '0;
        dig_valid = 1'b0;
        if (i_ch >= aip_pkg::CH_ZERO && i_ch <= aip_pkg::CH_NINE) begin
            dig       = 6'(i_ch - aip_pkg::CH_ZERO);
            dig_valid = 1'b1;
        end else if (i_ch >= aip_pkg::CH_LA && i_ch <= aip_pkg::CH_LZ) begin
            dig       = 6'(i_ch - aip_pkg::CH_LA) + 6'd10;
            dig_valid = 1'b1;
        end else if (i_ch >= aip_pkg::CH_UA && i_ch <= aip_pkg::CH_UZ) begin
            dig       = 6'(i_ch - aip_pkg::CH_UA) + 6'd10;
            dig_valid = 1'b1;
        end
    end

    always_comb begin
        unique case (i_cfg.base_mode)
            aip_pkg::BM_AUTO: base_sel = aip_pkg::BASE_AUTO;
            aip_pkg::BM_OCT:  base_sel = aip_pkg::BASE_8;
            aip_pkg::BM_HEX:  base_sel = aip_pkg::BASE_16;
            aip_pkg::BM_BIN:  base_sel = aip_pkg::BASE_2;
            default:          base_sel = aip_pkg::BASE_10;
        endcase
    end

    assign start_b = (i_state.phase == aip_pkg::PH_SKIP) ? base_sel : i_state.base;
    assign sign_ok = is_sign && (!i_cfg.width_limited || i_cfg.field_width != '0);
    assign room2   = !i_cfg.width_limited ||
                     ({1'b0, i_cfg.field_width} >= ({1'b0, i_state.used} + 17'd2));
    assign hold_ok = (start_b == aip_pkg::BASE_AUTO || start_b == aip_pkg::BASE_16) &&
                     room2 && is_zero && !i_last;

    always_comb begin
        unique case (i_state.phase)
            aip_pkg::PH_SKIP: begin
                if (is_nul)       op = aip_pkg::OP_EMPTY;
                else if (is_ws)   op = aip_pkg::OP_SPACE;
                else if (sign_ok) op = aip_pkg::OP_SIGN;
                else if (hold_ok) op = aip_pkg::OP_HOLD;
                else              op = aip_pkg::OP_DIGIT;
            end
            aip_pkg::PH_PREFIX: op = hold_ok ? aip_pkg::OP_HOLD : aip_pkg::OP_DIGIT;
            aip_pkg::PH_HOLD:   op = is_x ? aip_pkg::OP_XPFX : aip_pkg::OP_DIGIT;
            aip_pkg::PH_DIGITS: op = aip_pkg::OP_DIGIT;
            aip_pkg::PH_DONE:   op = i_last ? aip_pkg::OP_CLEAR : aip_pkg::OP_NONE;
            default:            op = aip_pkg::OP_NONE;
        endcase
    end

    always_comb begin
        if (i_state.phase == aip_pkg::PH_DIGITS) begin
            b_d = i_state.base;
        end else if (i_state.phase == aip_pkg::PH_HOLD) begin
            b_d = (i_state.base == aip_pkg::BASE_AUTO) ? aip_pkg::BASE_8 : i_state.base;
        end else if (start_b == aip_pkg::BASE_AUTO) begin
            b_d = is_zero ? aip_pkg::BASE_8 : aip_pkg::BASE_10;
        end else begin
            b_d = start_b;
        end
    end

    assign used1  = (i_state.used == '1) ? i_state.used : i_state.used + 1'b1;
    assign used2  = (used1 == '1) ? used1 : used1 + 1'b1;
    assign total1 = (i_state.total == '1) ? i_state.total : i_state.total + 1'b1;
    assign total2 = (total1 == '1) ? total1 : total1 + 1'b1;

    assign wh_r = i_cfg.width_limited && (i_state.used >= i_cfg.field_width);
    assign wh_1 = i_cfg.width_limited && (used1 >= i_cfg.field_width);
    assign wh_2 = i_cfg.width_limited && (used2 >= i_cfg.field_width);

    // A held zero counts as a digit before the current character, unless the
    // width limit was already reached while the zero was held.
    assign pre_inc   = (i_state.phase == aip_pkg::PH_HOLD) && !wh_r;
    assign used_in   = pre_inc ? used1 : i_state.used;
    assign used_out  = pre_inc ? used2 : used1;
    assign total_in  = pre_inc ? total1 : i_state.total;
    assign total_out = pre_inc ? total2 : total1;
    assign wh_in     = pre_inc ? wh_1 : wh_r;
    assign wh_out    = pre_inc ? wh_2 : wh_1;
    assign dseen_in  = pre_inc || i_state.dseen;

    assign dig_ok  = dig_valid && (dig < {1'b0, b_d});
    assign stop    = is_nul || wh_in || !dig_ok;
    assign ds_emit = stop || i_last || wh_out;

    always_comb begin
        case (b_d)
            aip_pkg::BASE_2: begin
                mul_p = i_state.acc << 1;
                mul_n = i_state.nacc << 1;
            end
            aip_pkg::BASE_8: begin
                mul_p = i_state.acc << 3;
                mul_n = i_state.nacc << 3;
            end
            aip_pkg::BASE_16: begin
                mul_p = i_state.acc << 4;
                mul_n = i_state.nacc << 4;
            end
            default: begin
                mul_p = (i_state.acc << 3) + (i_state.acc << 1);
                mul_n = (i_state.nacc << 3) + (i_state.nacc << 1);
            end
        endcase
    end

    assign acc_new  = mul_p + aip_pkg::t_acc'(dig);
    assign nacc_new = mul_n - aip_pkg::t_acc'(dig);

    always_comb begin
        o_emit = 1'b0;
        fdseen = 1'b0;
        fempty = 1'b0;
        facc   = i_state.acc;
        fnacc  = i_state.nacc;
        fused  = i_state.used;
        ftotal = i_state.total;
        unique case (op)
            aip_pkg::OP_EMPTY: begin
                o_emit = 1'b1;
                fempty = 1'b1;
            end
            aip_pkg::OP_SPACE: begin
                o_emit = i_last;
                fempty = 1'b1;
                ftotal = total1;
            end
            aip_pkg::OP_SIGN: begin
                o_emit = i_last || wh_1;
                fused  = used1;
                ftotal = total1;
            end
            aip_pkg::OP_XPFX: begin
                o_emit = i_last || wh_2;
                fused  = used2;
                ftotal = total2;
            end
            aip_pkg::OP_DIGIT: begin
                o_emit = ds_emit;
                if (stop) begin
                    fdseen = dseen_in;
                    fused  = used_in;
                    ftotal = total_in;
                end else begin
                    fdseen = 1'b1;
                    facc   = acc_new;
                    fnacc  = nacc_new;
                    fused  = used_out;
                    ftotal = total_out;
                end
            end
            default: ;
        endcase
    end

    assign sel   = i_state.minus ? fnacc : facc;
    assign tot_x = aip_pkg::t_diff'(ftotal);
    assign use_x = aip_pkg::t_diff'(fused);
    assign diff  = (tot_x >= use_x) ? tot_x - use_x : '0;

    always_comb begin
        o_result = '0;
        if (fempty) begin
            o_result.status   = aip_pkg::ST_EMPTY;
            o_result.consumed = tot_x[aip_pkg::CONS_W-1:0];
        end else if (!fdseen) begin
            o_result.status   = aip_pkg::ST_NO_DIGITS;
            o_result.consumed = diff[aip_pkg::CONS_W-1:0];
        end else begin
            o_result.status   = aip_pkg::ST_MATCH;
            o_result.negative = i_state.minus;
            o_result.consumed = tot_x[aip_pkg::CONS_W-1:0];
            unique case (i_cfg.store_size)
                aip_pkg::SZ_8:
                    o_result.value = {{(aip_pkg::ACC_W-8){i_cfg.is_signed & sel[7]}},
                                      sel[7:0]};
                aip_pkg::SZ_16:
                    o_result.value = {{(aip_pkg::ACC_W-16){i_cfg.is_signed & sel[15]}},
                                      sel[15:0]};
                aip_pkg::SZ_32:
                    o_result.value = {{(aip_pkg::ACC_W-32){i_cfg.is_signed & sel[31]}},
                                      sel[31:0]};
                default:
                    o_result.value = sel;
            endcase
        end
    end

    always_comb begin
        o_state = i_state;
        unique case (op)
            aip_pkg::OP_CLEAR: o_state = aip_pkg::STATE_CLEAR;
            aip_pkg::OP_SPACE: o_state.total = total1;
            aip_pkg::OP_SIGN: begin
                o_state.minus = is_minus;
                o_state.used  = used1;
                o_state.total = total1;
                o_state.base  = base_sel;
                o_state.phase = aip_pkg::PH_PREFIX;
            end
            aip_pkg::OP_HOLD: begin
                o_state.base  = start_b;
                o_state.phase = aip_pkg::PH_HOLD;
            end
            aip_pkg::OP_XPFX: begin
                o_state.base  = aip_pkg::BASE_16;
                o_state.used  = used2;
                o_state.total = total2;
                o_state.phase = aip_pkg::PH_DIGITS;
            end
            aip_pkg::OP_DIGIT: begin
                o_state.base  = b_d;
                o_state.acc   = acc_new;
                o_state.nacc  = nacc_new;
                o_state.used  = used_out;
                o_state.total = total_out;
                o_state.dseen = 1'b1;
                o_state.phase = aip_pkg::PH_DIGITS;
            end
            default: ;
        endcase
        if (o_emit) begin
            if (i_last) begin
                o_state = aip_pkg::STATE_CLEAR;
            end else begin
                o_state.phase = aip_pkg::PH_DONE;
            end
        end
    end

endmodule

// ----- design/ascii_integer_parser_core.sv -----
// Top level of the ASCII integer parser; uses aip_pkg and aip_step.
// The input register feeds the step logic; the output register holds its result.
// Throughput: one character per cycle unless its result must wait behind a stalled one.
// The output register lets a new character enter while a result waits.
// Reset (synchronous, active low) clears the parse state and loads register defaults.
module ascii_integer_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_ch,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_value,
    output logic        o_negative,
    output logic [1:0]  o_status,
    output logic [15:0] o_consumed,
    input  logic        i_cfg_wen,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    aip_pkg::t_cfg    r_cfg;
    aip_pkg::t_state  r_state, n_state;
    aip_pkg::t_result step_res, r_res;
    logic r_in_valid, n_in_valid;
    logic r_out_valid, n_out_valid;
    logic [7:0] r_ch;
    logic r_last;
    logic step_emit, advance, accept_in;

    aip_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_ch     (r_ch),
        .i_last   (r_last),
        .o_state  (n_state),
        .o_emit   (step_emit),
        .o_result (step_res)
    );

    assign advance     = r_in_valid && (!step_emit || !r_out_valid || i_ready);
    assign o_ready     = !r_in_valid || advance;
    assign accept_in   = i_valid && o_ready;
    assign n_in_valid  = accept_in || (r_in_valid && !advance);
    assign n_out_valid = (advance && step_emit) || (r_out_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= aip_pkg::STATE_CLEAR;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= aip_pkg::CFG_RESET;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_index)
                aip_pkg::CFG_BASE_MODE:     r_cfg.base_mode     <= i_cfg_data[2:0];
                aip_pkg::CFG_IS_SIGNED:     r_cfg.is_signed     <= i_cfg_data[0];
                aip_pkg::CFG_STORE_SIZE:    r_cfg.store_size    <= i_cfg_data[1:0];
                aip_pkg::CFG_WIDTH_LIMITED: r_cfg.width_limited <= i_cfg_data[0];
                aip_pkg::CFG_FIELD_WIDTH:   r_cfg.field_width   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_ch   <= i_ch;
            r_last <= i_last;
        end
        if (advance && step_emit) begin
            r_res <= step_res;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_value    = r_res.value;
    assign o_negative = r_res.negative;
    assign o_status   = r_res.status;
    assign o_consumed = r_res.consumed;

endmodule

// ----- design/aip_checker.sv -----
// Port-level checker for the ASCII integer parser, bound to the top level.
// Depends on aip_pkg and assert_macros.svh.
`include "assert_macros.svh"

module aip_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_value,
    input logic        i_negative,
    input logic [1:0]  i_status,
    input logic [15:0] i_consumed
);

    `AIP_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_value) && $stable(i_negative) && $stable(i_status) && $stable(i_consumed)), "Result changed while stalled.")
    `AIP_ASSERT_IMPLY(a_status_code, i_clk, i_rst_n, i_out_valid, i_status == aip_pkg::ST_MATCH || i_status == aip_pkg::ST_NO_DIGITS || i_status == aip_pkg::ST_EMPTY, "Undefined status code.")
    `AIP_ASSERT_IMPLY(a_fail_zero, i_clk, i_rst_n, i_out_valid && i_status != aip_pkg::ST_MATCH, i_value == '0 && !i_negative, "Failed match carries a value.")
    `AIP_ASSERT_IMPLY(a_stall_only, i_clk, i_rst_n, !i_in_ready, i_out_valid && !i_out_ready, "Input blocked without an output stall.")

endmodule

bind ascii_integer_parser_core aip_checker u_aip_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (o_ready),
    .i_out_valid (o_valid),
    .i_out_ready (i_ready),
    .i_value     (o_value),
    .i_negative  (o_negative),
    .i_status    (o_status),
    .i_consumed  (o_consumed)
);

// ----- tb/sv/ascii_integer_parser_checker.sv -----
// Checker for the ASCII integer parser: predicts each result from the character stream.
// It compares the results field by field. Depends on aip_pkg.
`timescale 1ns / 100ps

module ascii_integer_parser_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_ch,
    input  logic        i_in_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [63:0] i_out_value,
    input  logic        i_out_negative,
    input  logic [1:0]  i_out_status,
    input  logic [15:0] i_out_consumed,
    input  logic        i_cfg_wen,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_pending,
    output int          o_fail_count,
    output int          o_checked
);

    localparam longint unsigned TOTAL_TOP = (64'd1 << aip_pkg::COUNT_BITS) - 64'd1;

    logic [2:0]      mode_sel;
    logic            sign_ext;
    logic [1:0]      size_sel;
    logic            limit_on;
    logic [15:0]     limit_chars;

    aip_pkg::t_phase ph;
    aip_pkg::t_acc   acc;
    int unsigned     used_n;
    longint unsigned total_n;
    aip_pkg::t_base  base;
    logic            minus;
    logic            dseen;

    aip_pkg::t_result parsed_q[$];
    int               errors;
    int               checked;

    function automatic void restart_text();
        ph      = aip_pkg::PH_SKIP;
        acc     = '0;
        used_n  = 0;
        total_n = 0;
        base    = aip_pkg::BASE_10;
        minus   = 1'b0;
        dseen   = 1'b0;
    endfunction

    function automatic void bump_total();
        if (total_n < TOTAL_TOP) total_n++;
    endfunction

    function automatic void bump_used();
        if (used_n < 32'hFFFF) used_n++;
    endfunction

    function automatic bit width_full();
        return limit_on && (used_n >= limit_chars);
    endfunction

    function automatic int digit_weight(logic [7:0] c);
        if (c >= aip_pkg::CH_ZERO && c <= aip_pkg::CH_NINE)
            return int'(c) - int'(aip_pkg::CH_ZERO);
        if (c >= aip_pkg::CH_LA && c <= aip_pkg::CH_LZ)
            return int'(c) - int'(aip_pkg::CH_LA) + 10;
        if (c >= aip_pkg::CH_UA && c <= aip_pkg::CH_UZ)
            return int'(c) - int'(aip_pkg::CH_UA) + 10;
        return -1;
    endfunction

    function automatic bit deliver(aip_pkg::t_acc v, logic neg, logic [1:0] st,
                                   longint unsigned cons, bit fin,
                                   output aip_pkg::t_result r);
        r.value    = v;
        r.negative = neg;
        r.status   = st;
        r.consumed = cons[15:0];
        if (fin) restart_text();
        else ph = aip_pkg::PH_DONE;
        return 1'b1;
    endfunction

    function automatic bit close_number(bit fin, output aip_pkg::t_result r);
        aip_pkg::t_acc v;
        aip_pkg::t_acc mask;
        int            bits;
        if (dseen) begin
            v    = minus ? -acc : acc;
            bits = 8 << size_sel;
            if (bits < 64) begin
                mask = (64'd1 << bits) - 64'd1;
                v    = v & mask;
                if (sign_ext && v[bits-1]) v = v | ~mask;
            end
            return deliver(v, minus, aip_pkg::ST_MATCH, total_n, fin, r);
        end
        return deliver('0, 1'b0, aip_pkg::ST_NO_DIGITS,
                       (total_n >= used_n) ? total_n - used_n : 0, fin, r);
    endfunction

    function automatic bit take_digit(logic [7:0] c, bit fin, output aip_pkg::t_result r);
        int d;
        if (c == aip_pkg::CH_NUL || width_full()) return close_number(fin, r);
        d = digit_weight(c);
        if (d < 0 || d >= int'(base)) return close_number(fin, r);
        acc   = acc * aip_pkg::t_acc'(base) + aip_pkg::t_acc'(d);
        bump_used();
        bump_total();
        dseen = 1'b1;
        if (fin || width_full()) return close_number(fin, r);
        return 1'b0;
    endfunction

    function automatic bit open_number(logic [7:0] c, bit fin, output aip_pkg::t_result r);
        bit room;
        if (c == aip_pkg::CH_NUL) return close_number(fin, r);
        room = !limit_on || (limit_chars >= used_n + 2);
        if ((base == aip_pkg::BASE_AUTO || base == aip_pkg::BASE_16) && room &&
            c == aip_pkg::CH_ZERO && !fin) begin
            ph = aip_pkg::PH_HOLD;
            return 1'b0;
        end
        if (base == aip_pkg::BASE_AUTO)
            base = (c == aip_pkg::CH_ZERO) ? aip_pkg::BASE_8 : aip_pkg::BASE_10;
        ph = aip_pkg::PH_DIGITS;
        return take_digit(c, fin, r);
    endfunction

    function automatic bit after_zero(logic [7:0] c, bit fin, output aip_pkg::t_result r);
        ph = aip_pkg::PH_DIGITS;
        if (c == aip_pkg::CH_LX || c == aip_pkg::CH_UX) begin
            base = aip_pkg::BASE_16;
            bump_used();
            bump_used();
            bump_total();
            bump_total();
            if (fin || width_full()) return close_number(fin, r);
            return 1'b0;
        end
        if (base == aip_pkg::BASE_AUTO) base = aip_pkg::BASE_8;
        void'(take_digit(aip_pkg::CH_ZERO, 1'b0, r));
        return take_digit(c, fin, r);
    endfunction

    function automatic bit parse_char(logic [7:0] c, bit fin, output aip_pkg::t_result r);
        case (ph)
            aip_pkg::PH_SKIP: begin
                if (c == aip_pkg::CH_NUL)
                    return deliver('0, 1'b0, aip_pkg::ST_EMPTY, total_n, fin, r);
                if (c == aip_pkg::CH_SPACE || (c >= aip_pkg::CH_TAB && c <= aip_pkg::CH_CR)) begin
                    bump_total();
                    if (fin) return deliver('0, 1'b0, aip_pkg::ST_EMPTY, total_n, 1'b1, r);
                    return 1'b0;
                end
                case (mode_sel)
                    aip_pkg::BM_AUTO: base = aip_pkg::BASE_AUTO;
                    aip_pkg::BM_OCT:  base = aip_pkg::BASE_8;
                    aip_pkg::BM_HEX:  base = aip_pkg::BASE_16;
                    aip_pkg::BM_BIN:  base = aip_pkg::BASE_2;
                    default:          base = aip_pkg::BASE_10;
                endcase
                if ((c == aip_pkg::CH_PLUS || c == aip_pkg::CH_MINUS) &&
                    (!limit_on || limit_chars != 0)) begin
                    minus = (c == aip_pkg::CH_MINUS);
                    bump_used();
                    bump_total();
                    if (fin || width_full()) return close_number(fin, r);
                    ph = aip_pkg::PH_PREFIX;
                    return 1'b0;
                end
                return open_number(c, fin, r);
            end
            aip_pkg::PH_PREFIX: return open_number(c, fin, r);
            aip_pkg::PH_HOLD:   return after_zero(c, fin, r);
            aip_pkg::PH_DIGITS: return take_digit(c, fin, r);
            default: begin
                if (fin) restart_text();
                return 1'b0;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] result %0d, %s: got 0x%0h, expected 0x%0h",
                 $time, checked, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin : watch
        aip_pkg::t_result got;
        aip_pkg::t_result want;
        aip_pkg::t_result next_result;
        if (!i_rst_n) begin
            restart_text();
            mode_sel    = aip_pkg::CFG_RESET.base_mode;
            sign_ext    = aip_pkg::CFG_RESET.is_signed;
            size_sel    = aip_pkg::CFG_RESET.store_size;
            limit_on    = aip_pkg::CFG_RESET.width_limited;
            limit_chars = aip_pkg::CFG_RESET.field_width;
            parsed_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.value    = i_out_value;
                got.negative = i_out_negative;
                got.status   = i_out_status;
                got.consumed = i_out_consumed;
                if (parsed_q.size() == 0) begin
                    report_mismatch("result with nothing expected, value", got.value, '0);
                end else begin
                    want = parsed_q.pop_front();
                    if (got.value !== want.value)
                        report_mismatch("value", got.value, want.value);
                    if (got.negative !== want.negative)
                        report_mismatch("negative", 64'(got.negative), 64'(want.negative));
                    if (got.status !== want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                    if (got.consumed !== want.consumed)
                        report_mismatch("consumed", 64'(got.consumed), 64'(want.consumed));
                end
                checked++;
            end
            if (i_in_valid && i_in_ready) begin
                if (parse_char(i_in_ch, i_in_last, next_result))
                    parsed_q.push_back(next_result);
            end
            if (i_cfg_wen) begin
                case (i_cfg_index)
                    aip_pkg::CFG_BASE_MODE:     mode_sel    = i_cfg_data[2:0];
                    aip_pkg::CFG_IS_SIGNED:     sign_ext    = i_cfg_data[0];
                    aip_pkg::CFG_STORE_SIZE:    size_sel    = i_cfg_data[1:0];
                    aip_pkg::CFG_WIDTH_LIMITED: limit_on    = i_cfg_data[0];
                    aip_pkg::CFG_FIELD_WIDTH:   limit_chars = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending    <= parsed_q.size();
        o_fail_count <= errors;
        o_checked    <= checked;
    end

endmodule

// ----- tb/sv/ascii_integer_parser_core_tb.sv -----
// Testbench top for ascii_integer_parser_core: drives text and register writes.
// The verdict comes from ascii_integer_parser_checker; depends on aip_pkg.
`timescale 1ns / 100ps

module ascii_integer_parser_core_tb;

    localparam int STALL_LIMIT = 3000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_ch        = '0;
    logic        i_last      = 1'b0;
    logic        i_ready     = 1'b0;
    logic        i_cfg_wen   = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data  = '0;
    logic        o_ready;
    logic        o_valid;
    logic [63:0] o_value;
    logic        o_negative;
    logic [1:0]  o_status;
    logic [15:0] o_consumed;

    int          pending;
    int          fail_count;
    int          checked;
    int          quiet = 0;
    int          texts_sent = 0;
    int          chars_sent = 0;
    int          settings_used = 0;
    bit          calm = 1'b0;
    logic [2:0]  cur_mode = aip_pkg::BM_DEC;
    logic [7:0]  text_buf[$];

    ascii_integer_parser_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_ch        (i_ch),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_value     (o_value),
        .o_negative  (o_negative),
        .o_status    (o_status),
        .o_consumed  (o_consumed),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    ascii_integer_parser_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_in_ch        (i_ch),
        .i_in_last      (i_last),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_out_value    (o_value),
        .i_out_negative (o_negative),
        .i_out_status   (o_status),
        .i_out_consumed (o_consumed),
        .i_cfg_wen      (i_cfg_wen),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_pending      (pending),
        .o_fail_count   (fail_count),
        .o_checked      (checked)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (calm) i_ready <= 1'b1;
        else i_ready <= ($urandom_range(99) >= 36);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet <= 0;
        end else if (quiet >= STALL_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic send_char(input logic [7:0] c, input logic fin);
        while (!calm && $urandom_range(99) < 36) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ch    <= c;
        i_last  <= fin;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic send_buf();
        for (int k = 0; k < text_buf.size(); k++)
            send_char(text_buf[k], k == text_buf.size() - 1);
        texts_sent++;
    endtask

    task automatic send_text(input string s);
        text_buf.delete();
        for (int k = 0; k < s.len(); k++) text_buf.push_back(s[k]);
        send_buf();
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [15:0] data);
        i_cfg_wen   <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [2:0] mode, input logic sgn, input logic [1:0] sz,
                                  input logic lim, input logic [15:0] width);
        drain();
        put_reg(aip_pkg::CFG_BASE_MODE, {13'd0, mode});
        put_reg(aip_pkg::CFG_IS_SIGNED, {15'd0, sgn});
        put_reg(aip_pkg::CFG_STORE_SIZE, {14'd0, sz});
        put_reg(aip_pkg::CFG_WIDTH_LIMITED, {15'd0, lim});
        put_reg(aip_pkg::CFG_FIELD_WIDTH, width);
        i_cfg_wen <= 1'b0;
        cur_mode = mode;
        settings_used++;
    endtask

    task automatic build_random_text();
        int         n;
        int         radix;
        logic [7:0] d;
        text_buf.delete();
        if ($urandom_range(99) < 15) begin
            n = $urandom_range(1, 6);
            repeat (n) text_buf.push_back(8'($urandom_range(255)));
            return;
        end
        repeat ($urandom_range(0, 3))
            text_buf.push_back(($urandom_range(5) == 5) ? aip_pkg::CH_SPACE :
                               aip_pkg::CH_TAB + 8'($urandom_range(4)));
        case ($urandom_range(3))
            0: text_buf.push_back(aip_pkg::CH_MINUS);
            1: text_buf.push_back(aip_pkg::CH_PLUS);
            default: ;
        endcase
        case (cur_mode)
            aip_pkg::BM_BIN: radix = 2;
            aip_pkg::BM_OCT: radix = 8;
            aip_pkg::BM_HEX: radix = 16;
            default:         radix = 10;
        endcase
        if (cur_mode == aip_pkg::BM_AUTO || cur_mode == aip_pkg::BM_HEX) begin
            case ($urandom_range(3))
                0, 1: begin
                    text_buf.push_back(aip_pkg::CH_ZERO);
                    text_buf.push_back($urandom_range(1) ? aip_pkg::CH_LX : aip_pkg::CH_UX);
                    radix = 16;
                end
                2: begin
                    text_buf.push_back(aip_pkg::CH_ZERO);
                    if (cur_mode == aip_pkg::BM_AUTO) radix = 8;
                end
                default: ;
            endcase
        end
        n = ($urandom_range(9) == 0) ? $urandom_range(0, 25) : $urandom_range(0, 8);
        repeat (n) begin
            d = 8'($urandom_range(0, radix - 1));
            if (d < 10) text_buf.push_back(aip_pkg::CH_ZERO + d);
            else text_buf.push_back(($urandom_range(1) ? aip_pkg::CH_LA : aip_pkg::CH_UA) +
                                    d - 8'd10);
        end
        case ($urandom_range(3))
            0: text_buf.push_back(8'($urandom_range(255)));
            1: text_buf.push_back(aip_pkg::CH_NUL);
            default: ;
        endcase
        repeat ($urandom_range(0, 2)) text_buf.push_back(8'($urandom_range(255)));
        if (text_buf.size() == 0) text_buf.push_back(aip_pkg::CH_ZERO + 8'($urandom_range(9)));
    endtask

    initial begin : stimulus
        int          phase_left;
        int          random_texts;
        int          chars_at_start;
        logic [2:0]  mode;
        logic [15:0] width;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_text("  -42");
        send_text("+7x");
        send_text("\t\013\014\015 ");
        send_char(aip_pkg::CH_NUL, 1'b1);
        texts_sent++;
        send_text("abc");
        send_text("4294967295");
        send_char(aip_pkg::CH_NINE, 1'b0);
        send_char(8'hFF, 1'b1);
        texts_sent++;

        apply_settings(aip_pkg::BM_AUTO, 1'b1, aip_pkg::SZ_64, 1'b0, 16'd0);
        send_text("0x1F");
        send_text("017");
        send_text("0");
        send_text("0x");
        send_text("0xg");
        send_text("-0X7fffffffffffffff");
        send_text("089");

        apply_settings(aip_pkg::BM_HEX, 1'b0, aip_pkg::SZ_64, 1'b0, 16'd0);
        send_text("ffffffffffffffff");
        send_text("-0x8000000000000000");
        send_char(aip_pkg::CH_ZERO, 1'b0);
        send_char(aip_pkg::CH_LX, 1'b0);
        send_char(aip_pkg::CH_NUL, 1'b0);
        send_char(aip_pkg::CH_LZ, 1'b1);
        texts_sent++;

        apply_settings(aip_pkg::BM_BIN, 1'b1, aip_pkg::SZ_8, 1'b0, 16'd0);
        send_text("-101012");
        send_text("11111111");

        apply_settings(aip_pkg::BM_OCT, 1'b0, aip_pkg::SZ_16, 1'b0, 16'd0);
        send_text("-778");

        apply_settings(3'd7, 1'b1, aip_pkg::SZ_16, 1'b0, 16'd0);
        send_text("99999");

        apply_settings(aip_pkg::BM_DEC, 1'b1, aip_pkg::SZ_32, 1'b1, 16'd0);
        send_text("5");
        send_text("-5");

        apply_settings(aip_pkg::BM_AUTO, 1'b1, aip_pkg::SZ_32, 1'b1, 16'd1);
        send_text("-5");
        send_text("7");

        apply_settings(aip_pkg::BM_AUTO, 1'b1, aip_pkg::SZ_32, 1'b1, 16'd2);
        send_text("0x5");
        send_text("-0x5");
        send_text("123");

        apply_settings(aip_pkg::BM_DEC, 1'b0, aip_pkg::SZ_8, 1'b1, 16'hFFFF);
        send_text("123456");

        // A stretch of long numbers with both sides running at full rate.
        calm = 1'b1;
        apply_settings(aip_pkg::BM_DEC, 1'b1, aip_pkg::SZ_64, 1'b0, 16'd0);
        send_text("   18446744073709551615");
        send_text("-9223372036854775808");
        send_text("12345678901234567890123");
        send_text("+000000000000000000042");
        calm = 1'b0;

        phase_left     = 0;
        random_texts   = 0;
        chars_at_start = chars_sent;
        while (chars_sent - chars_at_start < 210 || random_texts < 20) begin
            if (phase_left == 0) begin
                mode = 3'(($urandom_range(9) == 0) ? $urandom_range(5, 7) :
                          $urandom_range(0, 4));
                case ($urandom_range(5))
                    0: width = 16'd0;
                    1: width = 16'd1;
                    2: width = 16'd2;
                    3: width = 16'hFFFF;
                    default: width = 16'($urandom_range(3, 24));
                endcase
                apply_settings(mode, 1'($urandom_range(1)), 2'($urandom_range(3)),
                               ($urandom_range(2) == 0), width);
                calm       = ($urandom_range(5) == 0);
                phase_left = $urandom_range(4, 8);
            end
            build_random_text();
            send_buf();
            random_texts++;
            phase_left--;
            if (random_texts == 3 || $urandom_range(19) == 0) drain();
        end

        calm = 1'b0;
        drain();
        $display("Sent %0d texts (%0d characters) under %0d register settings.",
                 texts_sent, chars_sent, settings_used);
        $display("Compared %0d results over every base mode, store size and width limit.",
                 checked);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/aip_pkg.sv
design/aip_step.sv
design/ascii_integer_parser_core.sv
design/aip_checker.sv
tb/sv/ascii_integer_parser_checker.sv
tb/sv/ascii_integer_parser_core_tb.sv
